### rtl/core/roc_pr_area_evaluator_defines.svh
// Assertion macros for the area evaluator RTL.
// No dependencies; included by roc_back, the module that carries assertions.
`ifndef ROC_PR_AREA_EVALUATOR_DEFINES_SVH
`define ROC_PR_AREA_EVALUATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define ROC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ROC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ROC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ROC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/roc_pkg.sv
// Shared constants and types for the ROC / PR area evaluator.
// No dependencies.
`default_nettype none
package roc_pkg;
	localparam int MAX_SAMPLES = 1024;
	localparam int SCORE_BITS  = 16;
	localparam int IN_SCORE_W  = 16;
	localparam int AREA_W      = 17;
	localparam int STATUS_W    = 2;
	localparam int ADDR_W      = $clog2(MAX_SAMPLES);
	localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
	localparam int ACC_W       = 2 * CNT_W;
	localparam int PREC_W      = 33;
	localparam int PR_W        = CNT_W + 34;
	localparam int DIV_W       = 2 * CNT_W;
	localparam int NUM_W       = (CNT_W + 32 > ACC_W + 16) ? CNT_W + 32 : ACC_W + 16;
	localparam int FQ_DEPTH    = 4;
	localparam int FQ_PTR_W    = $clog2(FQ_DEPTH);

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_POS  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_NEG  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd3;

	typedef struct packed {
		logic [SCORE_BITS-1:0] score;
		logic                  label;
		logic                  last;
		logic                  drop;
	} item_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DIV_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quo;
	} div_rsp_t;
endpackage
`default_nettype wire

### rtl/core/roc_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on roc_pkg.
`default_nettype none
module roc_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire roc_pkg::div_req_t req,
	output roc_pkg::div_rsp_t      rsp
);
	import roc_pkg::*;

	localparam int DC_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quo_q;
	logic [DIV_W-1:0] den_q;
	logic [DIV_W-1:0] rem_q;
	logic [DC_W-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W:0]   trial;
	logic             ge;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DC_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DC_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? DIV_W'(trial - {1'b0, den_q}) : trial[DIV_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
endmodule
`default_nettype wire

### rtl/core/roc_front.sv
// Input side: takes words, marks those past capacity, queues them for the back end.
// Depends on roc_pkg.
`default_nettype none
module roc_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  wire logic [roc_pkg::IN_SCORE_W-1:0] score,
	input  wire logic                           label,
	input  wire logic                           last,
	output logic                                item_valid,
	output roc_pkg::item_t                      item,
	input  wire logic                           item_pop
);
	import roc_pkg::*;

	item_t               fq_q [FQ_DEPTH];
	logic [FQ_PTR_W-1:0] wr_q;
	logic [FQ_PTR_W-1:0] rd_q;
	logic [FQ_PTR_W:0]   fill_q;
	logic [CNT_W-1:0]    kept_q;
	logic                acc;
	logic                deq;
	item_t               ent;

	assign full       = fill_q == (FQ_PTR_W+1)'(FQ_DEPTH);
	assign item_valid = fill_q != '0;
	assign acc        = push && !full;
	assign deq        = item_pop && item_valid;
	assign item       = fq_q[rd_q];

	always_comb begin
		ent.score = score[SCORE_BITS-1:0];
		ent.label = label;
		ent.last  = last;
		ent.drop  = kept_q == CNT_W'(MAX_SAMPLES);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
			kept_q <= '0;
		end else begin
			if (acc) begin
				wr_q <= wr_q + 1'b1;
				if (last)
					kept_q <= '0;
				else if (!ent.drop)
					kept_q <= kept_q + 1'b1;
			end
			if (deq)
				rd_q <= rd_q + 1'b1;
			if (acc && !deq)
				fill_q <= fill_q + 1'b1;
			else if (deq && !acc)
				fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc)
			fq_q[wr_q] <= ent;
	end
endmodule
`default_nettype wire

### rtl/core/roc_back.sv
// Back end: sorted insertion into the sample memory, curve walk, final areas.
// Depends on roc_pkg; uses the divider through req/rsp.
`default_nettype none
`include "roc_pr_area_evaluator_defines.svh"
module roc_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         item_valid,
	input  wire roc_pkg::item_t               item,
	output logic                              item_pop,
	output roc_pkg::div_req_t                 div_req,
	input  wire roc_pkg::div_rsp_t            div_rsp,
	output logic                              empty,
	input  wire logic                         pop,
	output logic [roc_pkg::AREA_W-1:0]        roc_area,
	output logic [roc_pkg::AREA_W-1:0]        pr_area,
	output logic [roc_pkg::STATUS_W-1:0]      status
);
	import roc_pkg::*;

	typedef enum logic [3:0] {
		IDLE, INS_RD, INS_CMP, W_INIT, W_RD, W_UPD, W_DIV,
		FIN, F_PR, F_MUL, F_ROC, OUT
	} state_t;

	localparam int WORD_W = SCORE_BITS + 1;

	state_t             st_q;
	item_t              ent_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   pcnt_q;
	logic               ovf_q;
	logic [CNT_W-1:0]   k_q;
	logic [CNT_W-1:0]   i_q;
	logic [CNT_W-1:0]   tp_q;
	logic [ACC_W-1:0]   roc_acc_q;
	logic [PR_W-1:0]    pr_acc_q;
	logic [PREC_W-1:0]  prev_q;
	logic               lab_q;
	logic [DIV_W-1:0]   prod_q;
	logic [AREA_W-1:0]  roc_r_q;
	logic [AREA_W-1:0]  pr_r_q;
	logic               out_valid_q;
	logic [AREA_W-1:0]  roc_out_q;
	logic [AREA_W-1:0]  pr_out_q;
	logic [STATUS_W-1:0] status_q;

	logic [WORD_W-1:0]  mem [MAX_SAMPLES];
	logic [WORD_W-1:0]  rd_word_q;
	logic [ADDR_W-1:0]  raddr;
	logic [ADDR_W-1:0]  waddr;
	logic [WORD_W-1:0]  wdata;
	logic               we;
	logic [CNT_W-1:0]   nneg;
	logic [CNT_W-1:0]   tp_n;
	logic [PREC_W-1:0]  prec;
	logic               rd_lab;
	logic [SCORE_BITS-1:0] rd_score;

	assign nneg     = cnt_q - pcnt_q;
	assign rd_lab   = rd_word_q[0];
	assign rd_score = rd_word_q[WORD_W-1:1];
	assign tp_n     = tp_q + CNT_W'(rd_lab);
	assign prec     = div_rsp.quo[PREC_W-1:0];
	assign item_pop = st_q == IDLE && item_valid;

	always_comb begin
		raddr = (st_q == INS_RD) ? ADDR_W'(k_q - 1'b1) : i_q[ADDR_W-1:0];
		we    = 1'b0;
		waddr = k_q[ADDR_W-1:0];
		wdata = {ent_q.score, ent_q.label};
		if (st_q == INS_RD && k_q == '0)
			we = 1'b1;
		if (st_q == INS_CMP) begin
			we = 1'b1;
			if (rd_score < ent_q.score)
				wdata = rd_word_q;
		end
	end

	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = '0;
		div_req.den   = '0;
		case (st_q)
			W_UPD: begin
				div_req.start = 1'b1;
				div_req.num   = NUM_W'({tp_n, 32'b0});
				div_req.den   = DIV_W'(i_q + 1'b1);
			end
			FIN: begin
				div_req.start = pcnt_q != '0;
				div_req.num   = NUM_W'(pr_acc_q[PR_W-1:17]);
				div_req.den   = DIV_W'(pcnt_q);
			end
			F_MUL: begin
				div_req.start = 1'b1;
				div_req.num   = NUM_W'({roc_acc_q, 16'b0});
				div_req.den   = prod_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_word_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= IDLE;
			cnt_q       <= '0;
			pcnt_q      <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && out_valid_q)
				out_valid_q <= 1'b0;
			case (st_q)
				IDLE: begin
					if (item_valid) begin
						ent_q <= item;
						k_q   <= cnt_q;
						if (item.drop) begin
							ovf_q <= 1'b1;
							st_q  <= item.last ? W_INIT : IDLE;
						end else begin
							st_q <= INS_RD;
						end
					end
				end
				INS_RD: begin
					if (k_q == '0) begin
						cnt_q  <= cnt_q + 1'b1;
						pcnt_q <= pcnt_q + CNT_W'(ent_q.label);
						st_q   <= ent_q.last ? W_INIT : IDLE;
					end else begin
						st_q <= INS_CMP;
					end
				end
				INS_CMP: begin
					if (rd_score >= ent_q.score) begin
						cnt_q  <= cnt_q + 1'b1;
						pcnt_q <= pcnt_q + CNT_W'(ent_q.label);
						st_q   <= ent_q.last ? W_INIT : IDLE;
					end else begin
						k_q  <= k_q - 1'b1;
						st_q <= INS_RD;
					end
				end
				W_INIT: begin
					i_q       <= '0;
					tp_q      <= '0;
					roc_acc_q <= '0;
					pr_acc_q  <= '0;
					prev_q    <= PREC_W'(64'h1_0000_0000);
					st_q      <= W_RD;
				end
				W_RD: begin
					st_q <= (i_q == cnt_q) ? FIN : W_UPD;
				end
				W_UPD: begin
					lab_q <= rd_lab;
					tp_q  <= tp_n;
					if (!rd_lab)
						roc_acc_q <= roc_acc_q + ACC_W'(tp_q);
					st_q <= W_DIV;
				end
				W_DIV: begin
					if (div_rsp.done) begin
						if (lab_q)
							pr_acc_q <= pr_acc_q + PR_W'(prev_q) + PR_W'(prec);
						prev_q <= prec;
						i_q    <= i_q + 1'b1;
						st_q   <= W_RD;
					end
				end
				FIN: begin
					if (pcnt_q == '0) begin
						roc_r_q <= '0;
						pr_r_q  <= '0;
						st_q    <= OUT;
					end else begin
						st_q <= F_PR;
					end
				end
				F_PR: begin
					if (div_rsp.done) begin
						pr_r_q <= div_rsp.quo[AREA_W-1:0];
						prod_q <= DIV_W'(pcnt_q) * DIV_W'(nneg);
						if (nneg == '0) begin
							roc_r_q <= '0;
							st_q    <= OUT;
						end else begin
							st_q <= F_MUL;
						end
					end
				end
				F_MUL: st_q <= F_ROC;
				F_ROC: begin
					if (div_rsp.done) begin
						roc_r_q <= div_rsp.quo[AREA_W-1:0];
						st_q    <= OUT;
					end
				end
				OUT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						roc_out_q   <= roc_r_q;
						pr_out_q    <= pr_r_q;
						if (ovf_q)
							status_q <= ST_DROPPED;
						else if (pcnt_q == '0)
							status_q <= ST_NO_POS;
						else if (nneg == '0)
							status_q <= ST_NO_NEG;
						else
							status_q <= ST_OK;
						cnt_q  <= '0;
						pcnt_q <= '0;
						ovf_q  <= 1'b0;
						st_q   <= IDLE;
					end
				end
				default: st_q <= IDLE;
			endcase
		end
	end

	assign empty    = !out_valid_q;
	assign roc_area = roc_out_q;
	assign pr_area  = pr_out_q;
	assign status   = status_q;

	`ROC_ASSERT_IMPL(a_pos_le_cnt, clk, arst_n, 1'b1, pcnt_q <= cnt_q)
	`ROC_ASSERT_IMPL(a_cmp_nonzero, clk, arst_n, st_q == INS_CMP, k_q != '0)
	`ROC_ASSERT_IMPL(a_walk_bound, clk, arst_n, st_q == W_UPD, i_q < cnt_q)
	`ROC_ASSERT_NEXT(a_out_clears, clk, arst_n, st_q == OUT && !out_valid_q, cnt_q == '0)
endmodule
`default_nettype wire

### rtl/core/roc_pr_area_evaluator.sv
// One result word per set, given after the last sample. Each sample is inserted by a
// scan of the sorted sample memory, which has one read port and one write port.
// The walk makes one divider pass per sample on the shared bit-serial divider,
// plus up to two more divider passes at the end. A 4-deep input queue takes words while
// the back end works. Asynchronous active-low reset clears sample counts, not memory.
`default_nettype none
module roc_pr_area_evaluator (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  wire logic [roc_pkg::IN_SCORE_W-1:0] score,
	input  wire logic                           label,
	input  wire logic                           last,
	output logic                                empty,
	input  wire logic                           pop,
	output logic [roc_pkg::AREA_W-1:0]          roc_area,
	output logic [roc_pkg::AREA_W-1:0]          pr_area,
	output logic [roc_pkg::STATUS_W-1:0]        status
);
	import roc_pkg::*;

	item_t    item;
	logic     item_valid;
	logic     item_pop;
	div_req_t div_req;
	div_rsp_t div_rsp;

	roc_front u_front (
		.clk, .arst_n, .push, .full, .score, .label, .last,
		.item_valid, .item, .item_pop
	);

	roc_div u_div (
		.clk, .arst_n, .req(div_req), .rsp(div_rsp)
	);

	roc_back u_back (
		.clk, .arst_n, .item_valid, .item, .item_pop, .div_req, .div_rsp,
		.empty, .pop, .roc_area, .pr_area, .status
	);
endmodule
`default_nettype wire

### bench/tb_roc_pr_area_evaluator.sv
// Testbench for roc_pr_area_evaluator: scored samples in, ROC / PR areas out per set.
// Uses roc_pkg for widths, capacity and status codes. A local predictor checks every
// result word.
`default_nettype none
module tb_roc_pr_area_evaluator;
	import roc_pkg::*;

	typedef struct {
		logic [IN_SCORE_W-1:0] score;
		logic                  label;
		logic                  last;
		int unsigned           gap;
		bit                    drain;
	} sample_t;

	typedef struct {
		logic [AREA_W-1:0]   roc;
		logic [AREA_W-1:0]   pr;
		logic [STATUS_W-1:0] status;
	} areas_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	logic [IN_SCORE_W-1:0] score = '0;
	logic                  label = 1'b0;
	logic                  last = 1'b0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic [AREA_W-1:0]     roc_area;
	logic [AREA_W-1:0]     pr_area;
	logic [STATUS_W-1:0]   status;

	roc_pr_area_evaluator dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.score(score), .label(label), .last(last),
		.empty(empty), .pop(pop),
		.roc_area(roc_area), .pr_area(pr_area), .status(status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	sample_t     pending_samples[$];
	areas_t      expected_areas[$];
	int unsigned errors = 0;
	int unsigned results_seen = 0;
	bit          tx_burst = 0;
	bit          rx_burst = 0;

	// predictor state: the current set, kept sorted by score, highest first
	logic [SCORE_BITS-1:0] ranked_score[MAX_SAMPLES];
	logic                  ranked_label[MAX_SAMPLES];
	int unsigned           held = 0;
	int unsigned           held_pos = 0;
	bit                    dropped = 0;

	function automatic void take_sample(logic [IN_SCORE_W-1:0] sc, logic lb, logic lst);
		int unsigned pos;
		int unsigned k;
		longint unsigned tp, roc_sum, pr_sum, prev_prec, prec, np, nn;
		areas_t e;
		if (held >= MAX_SAMPLES) begin
			dropped = 1;
		end else begin
			pos = 0;
			while (pos < held && ranked_score[pos] >= sc[SCORE_BITS-1:0])
				pos++;
			for (k = held; k > pos; k--) begin
				ranked_score[k] = ranked_score[k-1];
				ranked_label[k] = ranked_label[k-1];
			end
			ranked_score[pos] = sc[SCORE_BITS-1:0];
			ranked_label[pos] = lb;
			held++;
			if (lb)
				held_pos++;
		end
		if (!lst)
			return;
		np = held_pos;
		nn = held - held_pos;
		tp = 0;
		roc_sum = 0;
		pr_sum = 0;
		prev_prec = 64'd1 << 32;
		for (k = 0; k < held; k++) begin
			if (ranked_label[k])
				tp++;
			else
				roc_sum += tp;
			prec = (tp << 32) / (k + 1);
			if (ranked_label[k])
				pr_sum += prev_prec + prec;
			prev_prec = prec;
		end
		e.roc = '0;
		e.pr = '0;
		if (np != 0) begin
			e.pr = AREA_W'(pr_sum / (np << 17));
			if (nn != 0)
				e.roc = AREA_W'((roc_sum << 16) / (np * nn));
		end
		if (dropped)
			e.status = ST_DROPPED;
		else if (np == 0)
			e.status = ST_NO_POS;
		else if (nn == 0)
			e.status = ST_NO_NEG;
		else
			e.status = ST_OK;
		expected_areas = {expected_areas, e};
		held = 0;
		held_pos = 0;
		dropped = 0;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	function automatic void add_sample(logic [IN_SCORE_W-1:0] sc, logic lb, logic lst,
			bit drain);
		sample_t s;
		s.score = sc;
		s.label = lb;
		s.last = lst;
		s.drain = drain;
		s.gap = tx_burst ? 0 : $urandom_range(0, 15);
		pending_samples = {pending_samples, s};
	endfunction

	// one set of n samples; tie_pool > 0 draws scores from a few values to force ties
	function automatic void add_set(int unsigned n, int unsigned tie_pool, bit drain);
		int unsigned k;
		logic [IN_SCORE_W-1:0] sc;
		tx_burst = ($urandom_range(0, 3) == 0);
		for (k = 0; k < n; k++) begin
			sc = tie_pool != 0 ? IN_SCORE_W'($urandom_range(0, tie_pool - 1) * 13107)
				: IN_SCORE_W'($urandom);
			add_sample(sc, $urandom_range(0, 1), k == n - 1, drain && k == 0);
		end
	endfunction

	// sender
	int unsigned gap_left = 0;
	always @(posedge clk) begin
		sample_t s;
		if (arst_n) begin
			if (push && !full)
				take_sample(score, label, last);
			if (!push || !full) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					push <= 1'b0;
				end else if (pending_samples.size() != 0 &&
						!(pending_samples[0].drain && expected_areas.size() != 0)) begin
					s = pending_samples.pop_front();
					score <= s.score;
					label <= s.label;
					last <= s.last;
					gap_left <= s.gap;
					push <= 1'b1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// receiver
	int unsigned stall_left = 0;
	always @(posedge clk) begin
		int unsigned draw;
		areas_t e;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_areas.size() == 0) begin
					report_mismatch("unexpected result word, status", status, 0);
				end else begin
					e = expected_areas.pop_front();
					if (roc_area !== e.roc)
						report_mismatch("roc_area", roc_area, e.roc);
					if (pr_area !== e.pr)
						report_mismatch("pr_area", pr_area, e.pr);
					if (status !== e.status)
						report_mismatch("status", status, e.status);
				end
				results_seen++;
				if (results_seen % 16 == 0)
					rx_burst = ($urandom_range(0, 2) == 0);
				// long hold-off so the input side backs up and full asserts
				if (results_seen == 12)
					draw = 20000;
				else
					draw = rx_burst ? 0 : $urandom_range(0, 15);
				stall_left <= draw;
				pop <= (draw == 0);
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				pop <= (stall_left == 1);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		int unsigned k;
		// directed sets
		add_sample(16'hFFFF, 1'b1, 1'b1, 0);                // lone positive
		add_sample(16'h0000, 1'b0, 1'b1, 0);                // lone negative
		add_sample(16'hFFFF, 1'b1, 1'b0, 0);                // perfect ranking
		add_sample(16'h0000, 1'b0, 1'b1, 0);
		add_sample(16'h0000, 1'b1, 1'b0, 0);                // inverted ranking
		add_sample(16'hFFFF, 1'b0, 1'b1, 0);
		add_sample(16'h8000, 1'b0, 1'b0, 0);                // ties keep arrival order
		add_sample(16'h8000, 1'b1, 1'b0, 0);
		add_sample(16'h8000, 1'b0, 1'b0, 0);
		add_sample(16'h8000, 1'b1, 1'b1, 0);
		add_sample(16'h1234, 1'b1, 1'b0, 0);                // all positive
		add_sample(16'h00FF, 1'b1, 1'b0, 0);
		add_sample(16'hFF00, 1'b1, 1'b1, 0);
		add_sample(16'h5555, 1'b0, 1'b0, 0);                // all negative
		add_sample(16'hAAAA, 1'b0, 1'b1, 0);
		add_sample(16'h0001, 1'b1, 1'b0, 1);                // mixed, after a full drain
		add_sample(16'h7FFF, 1'b0, 1'b0, 0);
		add_sample(16'hFFFE, 1'b1, 1'b0, 0);
		add_sample(16'h0000, 1'b0, 1'b1, 0);
		// past capacity: the trailing samples, the last one too, are dropped
		for (k = 0; k < MAX_SAMPLES + 4; k++)
			add_sample(IN_SCORE_W'($urandom), $urandom_range(0, 1),
				k == MAX_SAMPLES + 3, k == 0);
		// random sets, mostly small
		k = 0;
		while (k < 700) begin
			case ($urandom_range(0, 9))
				0: begin add_set(32 + $urandom_range(0, 32), 0, 0); k += 48; end
				1, 2: begin add_set($urandom_range(2, 8), 4, 0); k += 5; end
				3: begin add_set($urandom_range(1, 6), 0, 1); k += 3; end
				default: begin add_set($urandom_range(1, 8), 0, 0); k += 4; end
			endcase
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_samples.size() == 0 && !push && expected_areas.size() == 0);
		repeat (2000) @(posedge clk);
		if (errors == 0 && expected_areas.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#20000000;
		$display("*** FAILED ***");
		$finish;
	end
endmodule
`default_nettype wire
